// File: rtl/core/btsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btsr_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int BUCKET_DEPTH = 32;
    localparam int HANDLE_WIDTH = 32;

    localparam int OP_W        = 2;
    localparam int BUCKET_W    = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int TOTAL_W     = 14;
    localparam int ACT_W       = 9;
    localparam int ACT_RESET   = 256;

    localparam int IDX_W       = $clog2(BUCKET_DEPTH);
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W      = BUCKET_W + IDX_W;
    localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_BAD_BUCKET = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MOVE,
        S_EMIT,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

// File: rtl/core/btsr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface btsr_in_if;
    logic                           valid;
    logic                           ready;
    logic [btsr_pkg::OP_W-1:0]      op;
    logic [btsr_pkg::BUCKET_W-1:0]  bucket;
    logic [btsr_pkg::VALUE_W-1:0]   item_handle;

    modport source (output valid, output op, output bucket, output item_handle, input ready);
    modport sink   (input valid, input op, input bucket, input item_handle, output ready);
endinterface

interface btsr_out_if;
    logic                           valid;
    logic                           ready;
    logic [btsr_pkg::VALUE_W-1:0]   item_value;
    logic [btsr_pkg::STATUS_W-1:0]  status;
    logic                           last;
    logic [btsr_pkg::TOTAL_W-1:0]   total_count;

    modport source (output valid, output item_value, output status, output last,
                    output total_count, input ready);
    modport sink   (input valid, input item_value, input status, input last,
                    input total_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bucket_table_swap_remove_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Bucket table with swap-remove. Command words arrive on i_in (op, bucket,
// item_handle) and result words leave on o_out (item_value, status, last,
// total_count). i_cfg_we/i_cfg_wdata set the number of active buckets.
// One command is handled at a time; i_in.ready is high only while idle.
// Remove: the bucket is scanned through the single read port of the handle
// memory, one entry per cycle. Read out: one result word per cycle while
// the receiver takes them, again one handle memory read per word.
// Op code 3 is dropped.
// A result word sits in the output register until o_out.ready is seen;
// while the receiver stalls, the sequencer holds and read out pauses.
// Reset (synchronous, active low) empties all buckets at once through
// per-bucket valid bits, clears the total and sets 256 active buckets.
// Handle memory contents are not cleared; only filled slots are read.
module bucket_table_swap_remove_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [btsr_pkg::ACT_W-1:0]       i_cfg_wdata,
    btsr_in_if.sink                         i_in,
    btsr_out_if.source                      o_out
);

    btsr_pkg::t_state                       r_state, n_state;
    btsr_pkg::t_op                          r_op;
    logic [btsr_pkg::BUCKET_W-1:0]          r_bucket;
    logic [btsr_pkg::HANDLE_WIDTH-1:0]      r_handle;
    btsr_pkg::t_status                      r_status, n_status;
    logic [btsr_pkg::IDX_W-1:0]             r_idx, n_idx;
    logic [btsr_pkg::FILL_W-1:0]            r_fill, n_fill;
    logic [btsr_pkg::TOTAL_W-1:0]           r_total, n_total;
    logic [btsr_pkg::ACT_W-1:0]             r_active;

    logic [btsr_pkg::HANDLE_WIDTH-1:0]      r_store [btsr_pkg::STORE_DEPTH];
    logic [btsr_pkg::HANDLE_WIDTH-1:0]      r_rd_data;
    logic [btsr_pkg::FILL_W-1:0]            r_fill_mem [btsr_pkg::NUM_BUCKETS];
    logic [btsr_pkg::FILL_W-1:0]            r_fill_rd;
    logic [btsr_pkg::NUM_BUCKETS-1:0]       r_fill_ok;
    logic                                   r_fill_vld;

    logic                                   r_o_valid, n_o_valid;
    logic [btsr_pkg::VALUE_W-1:0]           r_o_value;
    btsr_pkg::t_status                      r_o_status;
    logic                                   r_o_last;
    logic [btsr_pkg::TOTAL_W-1:0]           r_o_total;

    logic                                   accept;
    logic                                   out_free;
    logic                                   bad_bucket;
    logic [btsr_pkg::ACT_W-1:0]             limit;
    logic [btsr_pkg::FILL_W-1:0]            fill_cur;
    logic [btsr_pkg::FILL_W-1:0]            fill_dec;
    logic [btsr_pkg::FILL_W-1:0]            idx_inc;
    logic [btsr_pkg::IDX_W-1:0]             last_idx;
    logic                                   scan_last;
    logic                                   match;

    logic                                   st_we, st_re, fl_we, out_load;
    logic [btsr_pkg::ADDR_W-1:0]            st_waddr, st_raddr;
    logic [btsr_pkg::HANDLE_WIDTH-1:0]      st_wdata;
    logic [btsr_pkg::FILL_W-1:0]            fl_wdata;
    logic [btsr_pkg::VALUE_W-1:0]           out_value;
    btsr_pkg::t_status                      out_status;
    logic                                   out_last;

    assign i_in.ready        = (r_state == btsr_pkg::S_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign out_free          = !r_o_valid || o_out.ready;

    assign o_out.valid       = r_o_valid;
    assign o_out.item_value  = r_o_value;
    assign o_out.status      = r_o_status;
    assign o_out.last        = r_o_last;
    assign o_out.total_count = r_o_total;

    assign limit      = (r_active > btsr_pkg::ACT_W'(btsr_pkg::NUM_BUCKETS))
                      ? btsr_pkg::ACT_W'(btsr_pkg::NUM_BUCKETS) : r_active;
    assign bad_bucket = btsr_pkg::ACT_W'(i_in.bucket) >= limit;
    assign fill_cur   = r_fill_vld ? r_fill_rd : '0;
    assign fill_dec   = r_fill - btsr_pkg::FILL_W'(1);
    assign last_idx   = fill_dec[btsr_pkg::IDX_W-1:0];
    assign idx_inc    = btsr_pkg::FILL_W'(r_idx) + btsr_pkg::FILL_W'(1);
    assign scan_last  = (idx_inc == r_fill);
    assign match      = (r_rd_data == r_handle);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            btsr_pkg::S_IDLE: begin
                if (accept) begin
                    if (btsr_pkg::t_op'(i_in.op) == btsr_pkg::OP_NONE) begin
                        n_state = btsr_pkg::S_IDLE;
                    end else if (bad_bucket) begin
                        n_state = btsr_pkg::S_RESP;
                    end else begin
                        n_state = btsr_pkg::S_DECODE;
                    end
                end
            end
            btsr_pkg::S_DECODE: begin
                unique case (r_op)
                    btsr_pkg::OP_ADD:    n_state = btsr_pkg::S_RESP;
                    btsr_pkg::OP_REMOVE: n_state = (fill_cur == '0) ? btsr_pkg::S_RESP
                                                                    : btsr_pkg::S_SCAN;
                    btsr_pkg::OP_READ:   n_state = (fill_cur == '0) ? btsr_pkg::S_RESP
                                                                    : btsr_pkg::S_EMIT;
                    default:             n_state = btsr_pkg::S_IDLE;
                endcase
            end
            btsr_pkg::S_SCAN: begin
                priority if (match) begin
                    n_state = btsr_pkg::S_MOVE;
                end else if (scan_last) begin
                    n_state = btsr_pkg::S_RESP;
                end else begin
                    n_state = btsr_pkg::S_SCAN;
                end
            end
            btsr_pkg::S_MOVE: n_state = btsr_pkg::S_RESP;
            btsr_pkg::S_EMIT: begin
                if (out_free && scan_last) begin
                    n_state = btsr_pkg::S_IDLE;
                end
            end
            btsr_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = btsr_pkg::S_IDLE;
                end
            end
            default: n_state = btsr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_status   = r_status;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_total    = r_total;
        st_we      = 1'b0;
        st_waddr   = {r_bucket, r_idx};
        st_wdata   = r_rd_data;
        st_re      = 1'b0;
        st_raddr   = {r_bucket, r_idx};
        fl_we      = 1'b0;
        fl_wdata   = fill_dec;
        out_load   = 1'b0;
        out_value  = '0;
        out_status = r_status;
        out_last   = 1'b1;
        unique case (r_state)
            btsr_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = bad_bucket ? btsr_pkg::ST_BAD_BUCKET : btsr_pkg::ST_OK;
                end
            end
            btsr_pkg::S_DECODE: begin
                n_fill = fill_cur;
                n_idx  = '0;
                unique case (r_op)
                    btsr_pkg::OP_ADD: begin
                        if (fill_cur == btsr_pkg::FILL_W'(btsr_pkg::BUCKET_DEPTH)) begin
                            n_status = btsr_pkg::ST_FULL;
                        end else begin
                            st_we    = 1'b1;
                            st_waddr = {r_bucket, fill_cur[btsr_pkg::IDX_W-1:0]};
                            st_wdata = r_handle;
                            fl_we    = 1'b1;
                            fl_wdata = fill_cur + btsr_pkg::FILL_W'(1);
                            n_total  = r_total + btsr_pkg::TOTAL_W'(1);
                        end
                    end
                    btsr_pkg::OP_REMOVE: begin
                        if (fill_cur == '0) begin
                            n_status = btsr_pkg::ST_NOT_FOUND;
                        end else begin
                            st_re    = 1'b1;
                            st_raddr = {r_bucket, {btsr_pkg::IDX_W{1'b0}}};
                        end
                    end
                    btsr_pkg::OP_READ: begin
                        if (fill_cur == '0) begin
                            n_status = btsr_pkg::ST_EMPTY;
                        end else begin
                            st_re    = 1'b1;
                            st_raddr = {r_bucket, {btsr_pkg::IDX_W{1'b0}}};
                        end
                    end
                    default: n_status = r_status;
                endcase
            end
            btsr_pkg::S_SCAN: begin
                priority if (match) begin
                    st_re    = 1'b1;
                    st_raddr = {r_bucket, last_idx};
                end else if (scan_last) begin
                    n_status = btsr_pkg::ST_NOT_FOUND;
                end else begin
                    n_idx    = idx_inc[btsr_pkg::IDX_W-1:0];
                    st_re    = 1'b1;
                    st_raddr = {r_bucket, idx_inc[btsr_pkg::IDX_W-1:0]};
                end
            end
            btsr_pkg::S_MOVE: begin
                st_we   = 1'b1;
                fl_we   = 1'b1;
                n_total = r_total - btsr_pkg::TOTAL_W'(1);
            end
            btsr_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_value  = btsr_pkg::VALUE_W'(r_rd_data);
                    out_status = btsr_pkg::ST_OK;
                    out_last   = scan_last;
                    if (!scan_last) begin
                        n_idx    = idx_inc[btsr_pkg::IDX_W-1:0];
                        st_re    = 1'b1;
                        st_raddr = {r_bucket, idx_inc[btsr_pkg::IDX_W-1:0]};
                    end
                end
            end
            btsr_pkg::S_RESP: begin
                out_load = out_free;
            end
            default: n_status = r_status;
        endcase
    end

    assign n_o_valid = out_load | (r_o_valid & ~o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= btsr_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_total   <= '0;
            r_active  <= btsr_pkg::ACT_W'(btsr_pkg::ACT_RESET);
            r_fill_ok <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_total   <= n_total;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (fl_we) begin
                r_fill_ok[r_bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= btsr_pkg::t_op'(i_in.op);
            r_bucket   <= i_in.bucket;
            r_handle   <= i_in.item_handle[btsr_pkg::HANDLE_WIDTH-1:0];
            r_fill_rd  <= r_fill_mem[i_in.bucket];
            r_fill_vld <= r_fill_ok[i_in.bucket];
        end
        r_status <= n_status;
        r_idx    <= n_idx;
        r_fill   <= n_fill;
        if (out_load) begin
            r_o_value  <= out_value;
            r_o_status <= out_status;
            r_o_last   <= out_last;
            r_o_total  <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_rd_data <= r_store[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_fill_mem[r_bucket] <= fl_wdata;
        end
    end

endmodule
`default_nettype wire

// File: bench/tb_bucket_table_swap_remove_unit.sv
`timescale 1ns / 1ps
module tb_bucket_table_swap_remove_unit;

    localparam int QUIET_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 47;
    localparam logic [PHASES*btsr_pkg::ACT_W-1:0] PHASE_ACTIVE = {
        9'd6, 9'd256, 9'd3, 9'd1, 9'd511, 9'd2, 9'd256, 9'd4
    };

    typedef struct packed {
        logic [btsr_pkg::VALUE_W-1:0] value;
        btsr_pkg::t_status            status;
        logic                         last;
        logic [btsr_pkg::TOTAL_W-1:0] total;
    } t_result_word;

    typedef struct packed {
        logic                          cfg;
        logic [btsr_pkg::ACT_W-1:0]    cfg_val;
        btsr_pkg::t_op                 op;
        logic [btsr_pkg::BUCKET_W-1:0] bucket;
        logic [btsr_pkg::VALUE_W-1:0]  handle;
        logic [5:0]                    reps;
        logic                          typed;
        t_result_word                  want;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [btsr_pkg::ACT_W-1:0] i_cfg_wdata;

    btsr_in_if  in_if ();
    btsr_out_if out_if ();

    bucket_table_swap_remove_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [btsr_pkg::VALUE_W-1:0] bucket_slots [btsr_pkg::NUM_BUCKETS][btsr_pkg::BUCKET_DEPTH];
    int unsigned                  bucket_level [btsr_pkg::NUM_BUCKETS];
    logic [btsr_pkg::TOTAL_W-1:0] held_total;
    logic [btsr_pkg::ACT_W-1:0]   active_buckets;

    t_result_word pending_results [$];
    t_plan_row    plan [$];

    int errors;
    int cycles;
    int words_sent;
    int results_checked;
    int status_seen [5];
    int send_idle_pct;
    int recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 60)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_checked, name, got, want));
    endtask

    function automatic void push_result(input logic [btsr_pkg::VALUE_W-1:0] value,
                                        input btsr_pkg::t_status status, input logic last);
        t_result_word w;
        w.value  = value;
        w.status = status;
        w.last   = last;
        w.total  = held_total;
        pending_results.push_back(w);
    endfunction

    function automatic void apply_command(input btsr_pkg::t_op op,
                                          input logic [btsr_pkg::BUCKET_W-1:0] b,
                                          input logic [btsr_pkg::VALUE_W-1:0] h);
        int unsigned limit;
        int unsigned lvl;
        bit          found;
        limit = (active_buckets > btsr_pkg::NUM_BUCKETS) ? btsr_pkg::NUM_BUCKETS
                                                         : active_buckets;
        if (op == btsr_pkg::OP_NONE)
            return;
        if (b >= limit) begin
            push_result('0, btsr_pkg::ST_BAD_BUCKET, 1'b1);
            return;
        end
        lvl = bucket_level[b];
        case (op)
            btsr_pkg::OP_ADD: begin
                if (lvl >= btsr_pkg::BUCKET_DEPTH) begin
                    push_result('0, btsr_pkg::ST_FULL, 1'b1);
                end else begin
                    bucket_slots[b][lvl] = h;
                    bucket_level[b] = lvl + 1;
                    held_total = held_total + btsr_pkg::TOTAL_W'(1);
                    push_result('0, btsr_pkg::ST_OK, 1'b1);
                end
            end
            btsr_pkg::OP_REMOVE: begin
                found = 1'b0;
                for (int i = 0; i < lvl && !found; i++) begin
                    if (bucket_slots[b][i] == h) begin
                        found = 1'b1;
                        bucket_slots[b][i] = bucket_slots[b][lvl-1];
                        bucket_level[b] = lvl - 1;
                        held_total = held_total - btsr_pkg::TOTAL_W'(1);
                    end
                end
                push_result('0, found ? btsr_pkg::ST_OK : btsr_pkg::ST_NOT_FOUND, 1'b1);
            end
            default: begin
                if (lvl == 0)
                    push_result('0, btsr_pkg::ST_EMPTY, 1'b1);
                for (int i = 0; i < lvl; i++)
                    push_result(bucket_slots[b][i], btsr_pkg::ST_OK, i + 1 == lvl);
            end
        endcase
    endfunction

    function automatic t_plan_row cmd(input btsr_pkg::t_op op,
                                      input logic [btsr_pkg::BUCKET_W-1:0] b,
                                      input logic [btsr_pkg::VALUE_W-1:0] h,
                                      input logic [5:0] reps);
        t_plan_row r;
        r = '0;
        r.op     = op;
        r.bucket = b;
        r.handle = h;
        r.reps   = reps;
        return r;
    endfunction

    function automatic t_plan_row fixed(input btsr_pkg::t_op op,
                                        input logic [btsr_pkg::BUCKET_W-1:0] b,
                                        input logic [btsr_pkg::VALUE_W-1:0] h,
                                        input btsr_pkg::t_status st,
                                        input logic [btsr_pkg::VALUE_W-1:0] value,
                                        input logic [btsr_pkg::TOTAL_W-1:0] total);
        t_plan_row r;
        r = cmd(op, b, h, 6'd0);
        r.typed       = 1'b1;
        r.want.value  = value;
        r.want.status = st;
        r.want.last   = 1'b1;
        r.want.total  = total;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [btsr_pkg::ACT_W-1:0] v);
        t_plan_row r;
        r = cmd(btsr_pkg::OP_NONE, '0, '0, 6'd0);
        r.cfg     = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input btsr_pkg::t_op op,
                             input logic [btsr_pkg::BUCKET_W-1:0] b,
                             input logic [btsr_pkg::VALUE_W-1:0] h, input logic typed,
                             input t_result_word want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.bucket      <= b;
        in_if.item_handle <= h;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        apply_command(op, b, h);
        if (typed)
            pending_results[pending_results.size()-1] = want;
        if (op != btsr_pkg::OP_NONE)
            words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_quiet(input int extra);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_active(input logic [btsr_pkg::ACT_W-1:0] v);
        wait_quiet(QUIET_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_buckets = v;
    endtask

    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (out_if.status < 5)
                status_seen[out_if.status]++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word status %0d value %0h",
                                          out_if.status, out_if.item_value));
            end else begin
                want = pending_results.pop_front();
                check_field("item_value", out_if.item_value, want.value);
                check_field("status", 32'(out_if.status), 32'(want.status));
                check_field("last", 32'(out_if.last), 32'(want.last));
                check_field("total_count", 32'(out_if.total_count), 32'(want.total));
            end
            results_checked++;
        end
    end

    initial begin
        int            p;
        int            sent;
        int unsigned   limit;
        int unsigned   lvl;
        int            r;
        bit            paused;
        btsr_pkg::t_op op;
        logic [7:0]    b;
        logic [31:0]   h;

        errors          = 0;
        cycles          = 0;
        words_sent      = 0;
        results_checked = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        for (int i = 0; i < 5; i++)
            status_seen[i] = 0;
        for (int i = 0; i < btsr_pkg::NUM_BUCKETS; i++)
            bucket_level[i] = 0;
        held_total     = '0;
        active_buckets = btsr_pkg::ACT_W'(btsr_pkg::ACT_RESET);

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.op          = btsr_pkg::OP_ADD;
        in_if.bucket      = '0;
        in_if.item_handle = '0;
        out_if.ready      = 1'b0;

        plan.push_back(fixed(btsr_pkg::OP_READ, 8'd0, 32'h0, btsr_pkg::ST_EMPTY,
                             32'h0, 14'd0));
        plan.push_back(fixed(btsr_pkg::OP_REMOVE, 8'd7, 32'h1234, btsr_pkg::ST_NOT_FOUND,
                             32'h0, 14'd0));
        plan.push_back(fixed(btsr_pkg::OP_ADD, 8'd255, 32'hFFFF_FFFF, btsr_pkg::ST_OK,
                             32'h0, 14'd1));
        plan.push_back(fixed(btsr_pkg::OP_ADD, 8'd0, 32'h0, btsr_pkg::ST_OK, 32'h0, 14'd2));
        plan.push_back(cmd(btsr_pkg::OP_NONE, 8'd3, 32'h5, 6'd0));
        plan.push_back(fixed(btsr_pkg::OP_READ, 8'd255, 32'h0, btsr_pkg::ST_OK,
                             32'hFFFF_FFFF, 14'd2));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd0, 32'hA5A5_A5A5, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd0, 32'h5A5A_5A5A, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd0, 32'hA5A5_A5A5, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd0, 32'h0, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd0, 32'h0, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd0, 32'hA5A5_A5A5, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd0, 32'h0, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd0, 32'h1234_5678, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd9, 32'h100, 6'd31));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd9, 32'hDEAD_BEEF, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd9, 32'h0, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd9, 32'h11F, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd9, 32'h100, 6'd0));
        plan.push_back(cfg_row(9'd1));
        plan.push_back(cmd(btsr_pkg::OP_REMOVE, 8'd255, 32'hFFFF_FFFF, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_ADD, 8'd1, 32'h1, 6'd0));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd0, 32'h0, 6'd0));
        plan.push_back(cfg_row(9'd0));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd0, 32'h0, 6'd0));
        plan.push_back(cfg_row(9'd511));
        plan.push_back(cmd(btsr_pkg::OP_READ, 8'd255, 32'h0, 6'd0));
        plan.push_back(cfg_row(9'd256));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].cfg) begin
                write_active(plan[i].cfg_val);
            end else begin
                for (int k = 0; k <= plan[i].reps; k++)
                    send_word(plan[i].op, plan[i].bucket, plan[i].handle + 32'(k),
                              plan[i].typed, plan[i].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            write_active(PHASE_ACTIVE[p*btsr_pkg::ACT_W +: btsr_pkg::ACT_W]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            limit  = (active_buckets > btsr_pkg::NUM_BUCKETS) ? btsr_pkg::NUM_BUCKETS
                                                              : active_buckets;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS) begin
                if (limit == 0 || $urandom_range(0, 99) < 8)
                    b = 8'($urandom_range(0, 255));
                else
                    b = 8'($urandom_range(0, ((limit < 4) ? limit : 4) - 1));
                lvl = (b < limit) ? bucket_level[b] : 0;
                r   = $urandom_range(0, 99);
                if (r < 3)
                    op = btsr_pkg::OP_NONE;
                else if (lvl == btsr_pkg::BUCKET_DEPTH)
                    op = (r < 25) ? btsr_pkg::OP_ADD
                       : (r < 75) ? btsr_pkg::OP_REMOVE : btsr_pkg::OP_READ;
                else
                    op = (r < 45) ? btsr_pkg::OP_ADD
                       : (r < 80) ? btsr_pkg::OP_REMOVE : btsr_pkg::OP_READ;
                r = $urandom_range(0, 99);
                if (op == btsr_pkg::OP_REMOVE && lvl > 0 && r < 75)
                    h = bucket_slots[b][$urandom_range(0, lvl - 1)];
                else if (op != btsr_pkg::OP_READ && r < 50)
                    h = $urandom_range(0, 7);
                else if (op == btsr_pkg::OP_ADD && r < 60)
                    h = 32'hFFFF_FFFF - $urandom_range(0, 3);
                else
                    h = $urandom;
                send_word(op, b, h, 1'b0, '0);
                if (op != btsr_pkg::OP_NONE)
                    sent++;
                if (!paused && sent == PHASE_WORDS / 2) begin
                    paused = 1'b1;
                    wait_quiet(0);
                end
            end
        end

        wait_quiet(QUIET_CYCLES);
        $display("Sent %0d commands and checked %0d result words across %0d bucket limits",
                 words_sent, results_checked, PHASES + 4);
        $display("Status mix: ok %0d, full %0d, not found %0d, bad bucket %0d, empty %0d",
                 status_seen[btsr_pkg::ST_OK], status_seen[btsr_pkg::ST_FULL],
                 status_seen[btsr_pkg::ST_NOT_FOUND], status_seen[btsr_pkg::ST_BAD_BUCKET],
                 status_seen[btsr_pkg::ST_EMPTY]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
